>>> rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and the digit-to-character mapping for the
// integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned BIN_W   = 32;  // Width converted in decimal mode.
  localparam int unsigned BCD_DIG = 10;  // Decimal digits for 32 bits.
  localparam int unsigned BCD_W   = 4 * BCD_DIG;
  localparam int unsigned CNT_W   = 5;   // Digit counts up to 16.

  typedef enum logic [1:0] {
    OP_DEC     = 2'd0,
    OP_HEX_LO  = 2'd1,
    OP_HEX_UP  = 2'd2,
    OP_HEX64   = 2'd3
  } op_t;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_A_LOWER = 8'h61;
  localparam logic [7:0] ASCII_A_UPPER = 8'h41;
  localparam logic [3:0] DIGIT_TEN     = 4'd10;

  // Maps one digit (0 to 15) to its ASCII code.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? ASCII_A_UPPER : ASCII_A_LOWER;
      if (d < DIGIT_TEN) begin
        digit_char = ASCII_ZERO + {4'b0, d};
      end else begin
        digit_char = base + {4'b0, d - DIGIT_TEN};
      end
    end
  endfunction

endpackage

>>> rtl/integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats one unsigned number as decimal or hex ASCII digits.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the input channel (in_valid high, in_stall low) carries a
//   value and an operation. The block then emits one output request per
//   digit, most significant first, with no leading zeros. The final digit
//   has is_last set and digit_count holding the number of digits.
//   in_stall stays high from acceptance until the last digit has been
//   loaded into the output register, so one number is handled at a time.
//   A hex number is handled in order: acceptance, stripping of leading zeros
//   one nibble at a time, latching of the digit count and then emission of
//   each digit; it has 8 digit slots in the 32-bit modes and 16 in the
//   64-bit mode. A decimal number first passes through the shift-and-add-3
//   converter and then takes the same path over its 10 digit slots.
//   The output register holds a digit while out_stall is high; the next
//   digit is produced only when that register is free, so a stall simply
//   freezes the sequencer while it emits digits. Reset returns the block
//   to idle and drops out_valid; no other state survives between numbers.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] value,
  input  logic [1:0]  operation,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_code,
  output logic        is_last,
  output logic [4:0]  digit_count
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_NORM = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                        state;
  logic [63:0]                   digits;
  logic [itoa_pkg::CNT_W-1:0]    remain;
  logic [itoa_pkg::CNT_W-1:0]    total;
  logic                          upper;
  logic                          in_accept;
  logic                          bcd_start;
  logic                          bcd_done;
  logic [itoa_pkg::BCD_W-1:0]    bcd;
  logic                          out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign bcd_start = in_accept && (operation == itoa_pkg::OP_DEC);
  assign out_free  = !out_valid || !out_stall;

  itoa_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (bcd_start),
    .bin   (value[itoa_pkg::BIN_W-1:0]),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= (operation == itoa_pkg::OP_DEC) ? ST_CONV : ST_NORM;
          end
        end
        ST_CONV: begin
          if (bcd_done) begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (remain == 5'd1 || digits[63:60] != 4'd0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (remain == 5'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: the digit register shifts one nibble per cycle, first to strip
  // leading zeros, then, unless the output stalls, to present each digit.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          upper <= (operation == itoa_pkg::OP_HEX_UP);
          if (operation == itoa_pkg::OP_HEX64) begin
            digits <= value;
            remain <= 5'd16;
          end else begin
            digits <= {value[31:0], 32'b0};
            remain <= (operation == itoa_pkg::OP_DEC) ? 5'd10 : 5'd8;
          end
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          digits <= {bcd, 24'b0};
        end
      end
      ST_NORM: begin
        if (remain == 5'd1 || digits[63:60] != 4'd0) begin
          total <= remain;
        end else begin
          digits <= {digits[59:0], 4'b0};
          remain <= remain - 5'd1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          char_code   <= itoa_pkg::digit_char(digits[63:60], upper);
          is_last     <= (remain == 5'd1);
          digit_count <= (remain == 5'd1) ? total : 5'd0;
          digits      <= {digits[59:0], 4'b0};
          remain      <= remain - 5'd1;
        end
      end
      default: begin
        digits <= digits;
      end
    endcase
  end

endmodule

>>> rtl/itoa_bcd.sv
// ----------------------------------------------------------------------------
// itoa_bcd
// Iterative binary-to-BCD converter for a 32-bit operand: one
// shift-and-add-3 step per cycle.
// ----------------------------------------------------------------------------
module itoa_bcd (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [itoa_pkg::BIN_W-1:0]    bin,
  output logic                          done,
  output logic [itoa_pkg::BCD_W-1:0]    bcd
);

  logic [itoa_pkg::BIN_W-1:0] bin_sh;
  logic [4:0]                 step;
  logic                       busy;
  logic [itoa_pkg::BCD_W-1:0] corr;

  // Add 3 to every digit that is 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < itoa_pkg::BCD_DIG; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        corr[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        corr[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_sh <= bin;
      bcd    <= '0;
    end else if (busy) begin
      bcd    <= {corr[itoa_pkg::BCD_W-2:0], bin_sh[itoa_pkg::BIN_W-1]};
      bin_sh <= {bin_sh[itoa_pkg::BIN_W-2:0], 1'b0};
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the integer-to-ASCII formatter digit by digit. A short table of
// hand-picked numbers comes first, then random numbers in all four radix
// modes. Characters are compared against the table text or a digit model.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [4:0] count;
  } digit_t;

  localparam int DIR_N     = 21;
  localparam int RAND_N    = 310;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN     = 64;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] value;
  logic [1:0]  operation;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  char_code;
  logic        is_last;
  logic [4:0]  digit_count;

  digit_t pending_chars [$];
  int     mismatches    = 0;
  int     chars_checked = 0;
  int     numbers_sent  = 0;
  int     per_mode [4]  = '{0, 0, 0, 0};
  bit     calm          = 1'b0;
  int     holds_wanted  = 0;
  int     holds_done    = 0;

  // Hand-picked numbers. An empty text means the digit model supplies the
  // expected characters.
  logic [63:0] dir_value [DIR_N] = '{
    64'd0, 64'd0, 64'd0, 64'd0,
    64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
    64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000,
    64'hDEAD_BEEF_0000_ABCD, 64'hFFFF_FFFF_0000_0000,
    64'd9, 64'd10, 64'd15, 64'd16,
    64'h0123_4567_89AB_CDEF, 64'h8000_0000_0000_0000,
    64'd1000000000, 64'd999999999, 64'hA5A5_A5A5_5A5A_5A5A
  };
  itoa_pkg::op_t dir_op [DIR_N] = '{
    itoa_pkg::OP_DEC, itoa_pkg::OP_HEX_LO, itoa_pkg::OP_HEX_UP, itoa_pkg::OP_HEX64,
    itoa_pkg::OP_DEC, itoa_pkg::OP_HEX_LO, itoa_pkg::OP_HEX_UP, itoa_pkg::OP_HEX64,
    itoa_pkg::OP_DEC, itoa_pkg::OP_HEX_LO, itoa_pkg::OP_HEX_UP, itoa_pkg::OP_HEX64,
    itoa_pkg::OP_DEC, itoa_pkg::OP_DEC, itoa_pkg::OP_HEX_LO, itoa_pkg::OP_HEX_LO,
    itoa_pkg::OP_HEX64, itoa_pkg::OP_HEX64, itoa_pkg::OP_DEC, itoa_pkg::OP_DEC,
    itoa_pkg::OP_HEX_LO
  };
  string dir_text [DIR_N] = '{
    "0", "0", "0", "0",
    "4294967295", "ffffffff", "FFFFFFFF", "ffffffffffffffff",
    "0", "0", "ABCD", "ffffffff00000000",
    "9", "10", "f", "10",
    "", "8000000000000000", "", "", ""
  };

  integer_to_ascii_formatter_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .operation   (operation),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_code   (char_code),
    .is_last     (is_last),
    .digit_count (digit_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the characters of one number, least significant digit first,
  // then queues them in emission order.
  function automatic void predict_digits(input logic [63:0] num, input itoa_pkg::op_t mode);
    logic [7:0]  rev [16];
    logic [31:0] dec;
    logic [63:0] hex;
    logic [3:0]  nib;
    int          n;
    n = 0;
    if (mode == itoa_pkg::OP_DEC) begin
      dec = num[31:0];
      do begin
        rev[n] = "0" + 8'(dec % 10);
        n++;
        dec = dec / 10;
      end while (dec != 0 && n < 16);
    end else begin
      hex = (mode == itoa_pkg::OP_HEX64) ? num : {32'd0, num[31:0]};
      do begin
        nib = hex[3:0];
        if (nib < 4'd10) begin
          rev[n] = "0" + {4'd0, nib};
        end else begin
          rev[n] = ((mode == itoa_pkg::OP_HEX_UP) ? "A" : "a") + {4'd0, nib} - 8'd10;
        end
        n++;
        hex = hex >> 4;
      end while (hex != 0 && n < 16);
    end
    for (int k = n - 1; k >= 0; k--) begin
      pending_chars.push_back('{rev[k], k == 0, (k == 0) ? 5'(n) : 5'd0});
    end
  endfunction

  task automatic send_number(input logic [63:0] num, input itoa_pkg::op_t mode,
                             input string text);
    int len;
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    value     <= num;
    operation <= mode;
    do @(posedge clk); while (in_stall);
    len = text.len();
    if (len == 0) begin
      predict_digits(num, mode);
    end else begin
      for (int i = 0; i < len; i++) begin
        pending_chars.push_back('{text[i], i == len - 1, (i == len - 1) ? 5'(len) : 5'd0});
      end
    end
    numbers_sent++;
    per_mode[mode]++;
  endtask

  // Draws a value that mixes full-width noise, random bit lengths, small
  // numbers and decimal digit-count boundaries.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [31:0] p;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: ;
      1: v = v >> $urandom_range(63);
      2: v = 64'($urandom_range(20));
      default: begin
        p = 1;
        repeat ($urandom_range(9)) p = p * 10;
        v = {v[63:32], p - 32'($urandom_range(1))};
      end
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  initial begin : sender
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    value     <= 64'd0;
    operation <= itoa_pkg::OP_DEC;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_number(dir_value[i], dir_op[i], dir_text[i]);
    end
    wait_drained();

    for (int i = 0; i < RAND_N; i++) begin
      // Hold the output side off for a long time while requests keep coming.
      if (i == 40) holds_wanted++;
      calm = (i >= 120 && i < 180);
      if (i == 200) wait_drained();
      send_number(random_value(), itoa_pkg::op_t'($urandom_range(3)), "");
    end
    calm = 1'b0;
    wait_drained();
    repeat (DRAIN) @(posedge clk);

    $display("Formatted %0d numbers (decimal %0d, hex lower %0d, hex upper %0d, hex 64 %0d).",
             numbers_sent, per_mode[itoa_pkg::OP_DEC], per_mode[itoa_pkg::OP_HEX_LO],
             per_mode[itoa_pkg::OP_HEX_UP], per_mode[itoa_pkg::OP_HEX64]);
    $display("Checked %0d characters with %0d mismatches.", chars_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_wanted > holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin : check_chars
    digit_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character, actual %h last %b count %0d",
                 $time, char_code, is_last, digit_count);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (char_code !== want.ch) begin
          $display("%0t: char_code mismatch, expected %h, actual %h", $time, want.ch, char_code);
          mismatches++;
        end
        if (is_last !== want.last) begin
          $display("%0t: is_last mismatch, expected %b, actual %b", $time, want.last, is_last);
          mismatches++;
        end
        if (digit_count !== want.count) begin
          $display("%0t: digit_count mismatch, expected %0d, actual %0d",
                   $time, want.count, digit_count);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Run timed out with %0d characters still expected.", pending_chars.size());
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
rtl/itoa_pkg.sv
rtl/itoa_bcd.sv
rtl/integer_to_ascii_formatter_top.sv
bench/testbench.sv
